FILE: hdl/tvt_pkg.sv
package tvt_pkg;

	localparam int VOICES          = 3;
	localparam int STEPS_DEF       = 48;
	localparam int PATTERNS_DEF    = 16;
	localparam int ORDER_DEPTH_DEF = 64;
	localparam int NOTES_DEF       = 64;

	localparam logic [15:0] STEP_TICKS_RST  = 16'd550;
	localparam logic [15:0] DUTY_RST        = 16'hf000;
	localparam logic [6:0]  SONG_LENGTH_RST = 7'd37;
	localparam logic [5:0]  LOOP_START_RST  = 6'd1;

	typedef enum logic [1:0] {
		MODE_TICK,
		MODE_PAT,
		MODE_ORD,
		MODE_FREQ
	} mode_t;

	typedef enum logic [1:0] {
		REG_STEP_TICKS,
		REG_DUTY,
		REG_SONG_LENGTH,
		REG_LOOP_START
	} reg_idx_t;

	// per-lane stage strobes and write enables
	typedef struct packed {
		logic ld_s2;
		logic pat_we;
		logic ld_s3;
		logic freq_we;
		logic ld_out;
		logic tick_s3;
	} lane_ctl_t;

	// remainder by restoring subtraction, eight narrow steps
	function automatic logic [7:0] mod_reduce(input logic [7:0] x, input int unsigned m);
		logic [15:0] r;
		r = {8'd0, x};
		for (int k = 7; k >= 0; k--) begin
			if (r >= 16'(m << k)) begin
				r = r - 16'(m << k);
			end
		end
		return r[7:0];
	endfunction

endpackage

FILE: hdl/three_voice_tracker_tone_generator_core.sv
// Three-voice tracker tone generator. Each input word is a tick or a write into the order
// list, a pattern cell or the frequency table; every word yields one result word with the
// buzzer, LED and mixed levels and the song position after it. Words stream at one per
// cycle unless in_stall holds the input off. The pipeline has one stage per memory on
// the lookup chain: order memory, the per-voice pattern banks, then the per-voice copies
// of the frequency table, followed by the accumulator update that feeds the output
// register. Memories are not cleared and there is no start-up pass. Registers at byte
// addresses 0, 4, 8, 12: ticks per step, duty threshold, song length, loop start.
module three_voice_tracker_tone_generator_core #(
	parameter int STEPS       = tvt_pkg::STEPS_DEF,
	parameter int PATTERNS    = tvt_pkg::PATTERNS_DEF,
	parameter int ORDER_DEPTH = tvt_pkg::ORDER_DEPTH_DEF,
	parameter int NOTES       = tvt_pkg::NOTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [3:0]  pattern_number,
	input  logic [1:0]  voice,
	input  logic [5:0]  slot,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        buzzer,
	output logic        led,
	output logic        mixed_high,
	output logic [5:0]  order_position,
	output logic [5:0]  step_position
);

	localparam int OW  = $clog2(ORDER_DEPTH);
	localparam int SW  = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int PW  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
	localparam int NW  = $clog2(NOTES);
	localparam int PD  = PATTERNS * STEPS;
	localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
	localparam logic [OW-1:0] LOOP_WRAP_RST = OW'(int'(tvt_pkg::LOOP_START_RST) % ORDER_DEPTH);

	// configuration
	logic [15:0] step_ticks_q;
	logic [15:0] duty_q;
	logic [6:0]  song_length_q;
	logic [5:0]  loop_start_q;
	logic [OW-1:0] loop_wrap_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ticks_q  <= tvt_pkg::STEP_TICKS_RST;
			duty_q        <= tvt_pkg::DUTY_RST;
			song_length_q <= tvt_pkg::SONG_LENGTH_RST;
			loop_start_q  <= tvt_pkg::LOOP_START_RST;
			loop_wrap_q   <= LOOP_WRAP_RST;
		end else if (cfg_wr) begin
			case (tvt_pkg::reg_idx_t'(paddr[3:2]))
				tvt_pkg::REG_STEP_TICKS:  step_ticks_q <= pwdata[15:0];
				tvt_pkg::REG_DUTY:        duty_q <= pwdata[15:0];
				tvt_pkg::REG_SONG_LENGTH: song_length_q <= pwdata[6:0];
				tvt_pkg::REG_LOOP_START: begin
					loop_start_q <= pwdata[5:0];
					loop_wrap_q  <= OW'(tvt_pkg::mod_reduce({2'b00, pwdata[5:0]}, ORDER_DEPTH));
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (tvt_pkg::reg_idx_t'(paddr[3:2]))
			tvt_pkg::REG_STEP_TICKS:  prdata = {16'd0, step_ticks_q};
			tvt_pkg::REG_DUTY:        prdata = {16'd0, duty_q};
			tvt_pkg::REG_SONG_LENGTH: prdata = {25'd0, song_length_q};
			tvt_pkg::REG_LOOP_START:  prdata = {26'd0, loop_start_q};
			default:                  prdata = '0;
		endcase
	end

	// pipeline control
	logic v_s1, v_s2, v_s3;
	logic ld_s1, ld_s2, ld_s3, ld_out;

	assign ld_out   = v_s3 && (!out_valid || !out_stall);
	assign ld_s3    = v_s2 && (!v_s3 || ld_out);
	assign ld_s2    = v_s1 && (!v_s2 || ld_s3);
	assign in_stall = v_s1 && !ld_s2;
	assign ld_s1    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ld_s1 || ld_s2) v_s1 <= ld_s1;
			if (ld_s2 || ld_s3) v_s2 <= ld_s2;
			if (ld_s3 || ld_out) v_s3 <= ld_s3;
			if (ld_out || !out_stall) out_valid <= ld_out;
		end
	end

	// song position, advanced as each tick is taken
	tvt_pkg::mode_t mode_in;
	logic [15:0] tick_q, tick_d, tick_inc;
	logic [SW-1:0] step_q, step_d;
	logic [SW:0]   step_inc;
	logic [OW-1:0] order_q, order_d;
	logic [OW:0]   ord_inc;

	assign mode_in  = tvt_pkg::mode_t'(mode);
	assign tick_inc = tick_q + 16'd1;
	assign step_inc = {1'b0, step_q} + (SW+1)'(1);
	assign ord_inc  = {1'b0, order_q} + (OW+1)'(1);

	always_comb begin
		tick_d  = tick_q;
		step_d  = step_q;
		order_d = order_q;
		if (mode_in == tvt_pkg::MODE_TICK) begin
			if (tick_inc < step_ticks_q) begin
				tick_d = tick_inc;
			end else begin
				tick_d = '0;
				if (32'(step_inc) < STEPS) begin
					step_d = step_inc[SW-1:0];
				end else begin
					step_d = '0;
					if (32'(ord_inc) >= 32'(song_length_q) || 32'(ord_inc) >= ORDER_DEPTH) begin
						order_d = loop_wrap_q;
					end else begin
						order_d = ord_inc[OW-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			step_q  <= '0;
			order_q <= '0;
		end else if (ld_s1) begin
			tick_q  <= tick_d;
			step_q  <= step_d;
			order_q <= order_d;
		end
	end

	// stage 1: order memory
	logic [3:0] order_mem [ORDER_DEPTH];
	tvt_pkg::mode_t mode_s1;
	logic [3:0]  pnum_s1, pat_s1;
	logic [1:0]  voice_s1;
	logic [5:0]  slot_s1;
	logic [15:0] value_s1;
	logic [SW-1:0] step_s1;
	logic [OW-1:0] order_s1;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			if (mode_in == tvt_pkg::MODE_ORD && 32'(slot) < ORDER_DEPTH) begin
				order_mem[OW'(slot)] <= value[3:0];
			end
			pat_s1   <= order_mem[order_d];
			mode_s1  <= mode_in;
			pnum_s1  <= pattern_number;
			voice_s1 <= voice;
			slot_s1  <= slot;
			value_s1 <= value;
			step_s1  <= step_d;
			order_s1 <= order_d;
		end
	end

	logic [PW-1:0]  pat_red;
	logic [PAW-1:0] pat_addr;
	logic           pat_wr;

	assign pat_red = PW'(tvt_pkg::mod_reduce({4'd0, pat_s1}, PATTERNS));
	assign pat_wr  = mode_s1 == tvt_pkg::MODE_PAT && 32'(pnum_s1) < PATTERNS
		&& 32'(voice_s1) < tvt_pkg::VOICES && 32'(slot_s1) < STEPS;

	always_comb begin
		if (mode_s1 == tvt_pkg::MODE_PAT) begin
			pat_addr = PAW'(32'(pnum_s1) * STEPS + 32'(slot_s1));
		end else begin
			pat_addr = PAW'(32'(pat_red) * STEPS + 32'(step_s1));
		end
	end

	// stage 2: pattern banks (in lanes)
	tvt_pkg::mode_t mode_s2;
	logic [5:0]  slot_s2;
	logic [15:0] value_s2;
	logic [SW-1:0] step_s2;
	logic [OW-1:0] order_s2;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			mode_s2  <= mode_s1;
			slot_s2  <= slot_s1;
			value_s2 <= value_s1;
			step_s2  <= step_s1;
			order_s2 <= order_s1;
		end
	end

	// stage 3: frequency copies (in lanes)
	logic tick_s3;
	logic [SW-1:0] step_s3;
	logic [OW-1:0] order_s3;

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			tick_s3  <= mode_s2 == tvt_pkg::MODE_TICK;
			step_s3  <= step_s2;
			order_s3 <= order_s2;
		end
	end

	logic freq_wr;
	assign freq_wr = mode_s2 == tvt_pkg::MODE_FREQ && 32'(slot_s2) < NOTES;

	tvt_pkg::lane_ctl_t lane_ctl [tvt_pkg::VOICES];
	logic [5:0] note_w [tvt_pkg::VOICES];
	logic [tvt_pkg::VOICES-1:0] high_w;

	for (genvar v = 0; v < tvt_pkg::VOICES; v++) begin : g_lane
		always_comb begin
			lane_ctl[v].ld_s2   = ld_s2;
			lane_ctl[v].pat_we  = pat_wr && voice_s1 == 2'(v);
			lane_ctl[v].ld_s3   = ld_s3;
			lane_ctl[v].freq_we = freq_wr;
			lane_ctl[v].ld_out  = ld_out;
			lane_ctl[v].tick_s3 = tick_s3;
		end

		tvt_lane #(
			.STEPS(STEPS),
			.PATTERNS(PATTERNS),
			.NOTES(NOTES)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(lane_ctl[v]),
			.pat_addr(pat_addr),
			.pat_wdata(value_s1[5:0]),
			.freq_waddr(NW'(slot_s2)),
			.freq_wdata(value_s2),
			.duty(duty_q),
			.note(note_w[v]),
			.high(high_w[v])
		);
	end

	// output stage: levels update as a tick word leaves
	logic       mixed;
	logic [5:0] last_lead_q;
	logic       last_mixed_q, buzzer_q, led_q;
	logic [SW-1:0] step_out_q;
	logic [OW-1:0] order_out_q;

	assign mixed = |high_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_lead_q  <= '0;
			last_mixed_q <= 1'b0;
			buzzer_q     <= 1'b0;
			led_q        <= 1'b1;
		end else if (ld_out && tick_s3) begin
			if (mixed != last_mixed_q) begin
				buzzer_q     <= !buzzer_q;
				last_mixed_q <= mixed;
			end
			if (note_w[0] != last_lead_q) begin
				led_q <= note_w[0] != 6'd0;
			end
			last_lead_q <= note_w[0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			step_out_q  <= step_s3;
			order_out_q <= order_s3;
		end
	end

	assign buzzer         = buzzer_q;
	assign led            = led_q;
	assign mixed_high     = last_mixed_q;
	assign step_position  = 6'(step_out_q);
	assign order_position = 6'(order_out_q);

endmodule

FILE: hdl/tvt_lane.sv
module tvt_lane #(
	parameter int STEPS    = tvt_pkg::STEPS_DEF,
	parameter int PATTERNS = tvt_pkg::PATTERNS_DEF,
	parameter int NOTES    = tvt_pkg::NOTES_DEF,
	localparam int PD      = PATTERNS * STEPS,
	localparam int PAW     = (PD > 1) ? $clog2(PD) : 1,
	localparam int NW      = $clog2(NOTES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tvt_pkg::lane_ctl_t ctl,
	input  logic [PAW-1:0]     pat_addr,
	input  logic [5:0]         pat_wdata,
	input  logic [NW-1:0]      freq_waddr,
	input  logic [15:0]        freq_wdata,
	input  logic [15:0]        duty,
	output logic [5:0]         note,
	output logic               high
);

	logic [5:0]  pat_mem [PD];
	logic [15:0] freq_mem [NOTES];

	logic [5:0]  note_s2;
	logic [5:0]  note_s3;
	logic [15:0] freq_s3;
	logic [15:0] acc_q;
	logic [15:0] acc_sum;
	logic [NW-1:0] freq_raddr;

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			if (ctl.pat_we) begin
				pat_mem[pat_addr] <= pat_wdata;
			end
			note_s2 <= pat_mem[pat_addr];
		end
	end

	assign freq_raddr = NW'(tvt_pkg::mod_reduce({2'b00, note_s2}, NOTES));

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			if (ctl.freq_we) begin
				freq_mem[freq_waddr] <= freq_wdata;
			end
			freq_s3 <= freq_mem[freq_raddr];
			note_s3 <= note_s2;
		end
	end

	// note zero restarts the phase before the increment
	assign acc_sum = ((note_s3 == 6'd0) ? 16'd0 : acc_q) + freq_s3;
	assign high    = acc_sum > duty;
	assign note    = note_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.ld_out && ctl.tick_s3) begin
			acc_q <= acc_sum;
		end
	end

endmodule

FILE: hdl/tvt_checker.sv
module tvt_checker #(
	parameter int STEPS       = tvt_pkg::STEPS_DEF,
	parameter int ORDER_DEPTH = tvt_pkg::ORDER_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       buzzer,
	input logic       led,
	input logic       mixed_high,
	input logic [5:0] order_position,
	input logic [5:0] step_position
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(buzzer) && $stable(led)
			&& $stable(mixed_high) && $stable(order_position) && $stable(step_position))
		else $error("stalled result word changed");

	// with the output side empty the pipeline always drains, so input is never held off
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(step_position) < STEPS)
		else $error("step position out of range");

	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(order_position) < ORDER_DEPTH)
		else $error("order position out of range");

endmodule

bind three_voice_tracker_tone_generator_core tvt_checker #(
	.STEPS(STEPS),
	.ORDER_DEPTH(ORDER_DEPTH)
) u_tvt_checker (.*);

FILE: bench/tvt_checker.sv
module tvt_scoreboard #(
	parameter int STEPS       = tvt_pkg::STEPS_DEF,
	parameter int PATTERNS    = tvt_pkg::PATTERNS_DEF,
	parameter int ORDER_DEPTH = tvt_pkg::ORDER_DEPTH_DEF,
	parameter int NOTES       = tvt_pkg::NOTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [3:0]  pattern_number,
	input  logic [1:0]  voice,
	input  logic [5:0]  slot,
	input  logic [15:0] value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        buzzer,
	input  logic        led,
	input  logic        mixed_high,
	input  logic [5:0]  order_position,
	input  logic [5:0]  step_position,
	input  logic        end_check,
	output int unsigned fail_count,
	output int unsigned words_in_flight
);

	typedef struct packed {
		logic       buzzer;
		logic       led;
		logic       mixed;
		logic [5:0] order_pos;
		logic [5:0] step_pos;
	} levels_t;

	// register copies
	logic [15:0] step_ticks;
	logic [15:0] duty;
	logic [6:0]  song_len;
	logic [5:0]  loop_at;

	// song position and voice state
	logic [15:0] tick_cnt;
	logic [5:0]  step_idx;
	logic [5:0]  order_idx;
	logic [15:0] acc [tvt_pkg::VOICES];
	logic [5:0]  lead_note;
	logic        mixed_last;
	logic        buzz;
	logic        led_lvl;

	logic [5:0]  pat_cells [PATTERNS][tvt_pkg::VOICES][STEPS];
	logic [3:0]  order_tbl [ORDER_DEPTH];
	logic [15:0] freq_tbl [NOTES];

	levels_t     levels_due [$];
	int unsigned mismatches = 0;
	bit          end_seen = 1'b0;

	assign fail_count = mismatches;

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want) begin
			report($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	task automatic play_tick();
		int   nxt;
		int   pat;
		int   note;
		logic any_high;
		tick_cnt = tick_cnt + 16'd1;
		if (tick_cnt >= step_ticks) begin
			tick_cnt = '0;
			if (int'(step_idx) + 1 < STEPS) begin
				step_idx = step_idx + 6'd1;
			end else begin
				step_idx = '0;
				nxt = int'(order_idx) + 1;
				if (nxt >= int'(song_len) || nxt >= ORDER_DEPTH) begin
					nxt = int'(loop_at) % ORDER_DEPTH;
				end
				order_idx = 6'(nxt);
			end
		end
		pat = int'(order_tbl[int'(order_idx) % ORDER_DEPTH]) % PATTERNS;
		any_high = 1'b0;
		for (int v = 0; v < tvt_pkg::VOICES; v++) begin
			note = int'(pat_cells[pat][v][int'(step_idx) % STEPS]);
			// a rest restarts the phase before the increment is added
			if (note == 0) begin
				acc[v] = '0;
			end
			acc[v] = acc[v] + freq_tbl[note % NOTES];
			if (v == 0) begin
				if (6'(note) != lead_note) begin
					led_lvl = (note > 0);
				end
				lead_note = 6'(note);
			end
			if (acc[v] > duty) begin
				any_high = 1'b1;
			end
		end
		if (any_high != mixed_last) begin
			buzz = ~buzz;
			mixed_last = any_high;
		end
	endtask

	task automatic apply_word(input tvt_pkg::mode_t m, input logic [3:0] pn,
			input logic [1:0] vc, input logic [5:0] sl, input logic [15:0] val);
		case (m)
			tvt_pkg::MODE_TICK: begin
				play_tick();
			end
			tvt_pkg::MODE_PAT: begin
				if (pn < PATTERNS && vc < tvt_pkg::VOICES && sl < STEPS) begin
					pat_cells[pn][vc][sl] = val[5:0];
				end
			end
			tvt_pkg::MODE_ORD: begin
				if (sl < ORDER_DEPTH) begin
					order_tbl[sl] = val[3:0];
				end
			end
			tvt_pkg::MODE_FREQ: begin
				if (sl < NOTES) begin
					freq_tbl[sl] = val;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		levels_t want;
		if (!arst_n) begin
			step_ticks = tvt_pkg::STEP_TICKS_RST;
			duty = tvt_pkg::DUTY_RST;
			song_len = tvt_pkg::SONG_LENGTH_RST;
			loop_at = tvt_pkg::LOOP_START_RST;
			tick_cnt = '0;
			step_idx = '0;
			order_idx = '0;
			for (int v = 0; v < tvt_pkg::VOICES; v++) begin
				acc[v] = '0;
			end
			lead_note = '0;
			mixed_last = 1'b0;
			buzz = 1'b0;
			led_lvl = 1'b1;
			levels_due.delete();
			words_in_flight <= 0;
		end else begin
			// a result can never belong to the word taken on the same edge
			if (out_valid && !out_stall) begin
				if (levels_due.size() == 0) begin
					report("result word with nothing due");
				end else begin
					want = levels_due.pop_front();
					compare_field("buzzer", buzzer, want.buzzer);
					compare_field("led", led, want.led);
					compare_field("mixed_high", mixed_high, want.mixed);
					compare_field("order_position", order_position, want.order_pos);
					compare_field("step_position", step_position, want.step_pos);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (tvt_pkg::reg_idx_t'(paddr[3:2]))
					tvt_pkg::REG_STEP_TICKS:  step_ticks = pwdata[15:0];
					tvt_pkg::REG_DUTY:        duty = pwdata[15:0];
					tvt_pkg::REG_SONG_LENGTH: song_len = pwdata[6:0];
					tvt_pkg::REG_LOOP_START:  loop_at = pwdata[5:0];
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				apply_word(tvt_pkg::mode_t'(mode), pattern_number, voice, slot, value);
				levels_due.push_back('{buzz, led_lvl, mixed_last, order_idx, step_idx});
			end
			if (end_check && !end_seen) begin
				end_seen = 1'b1;
				if (levels_due.size() != 0) begin
					report($sformatf("%0d result words never arrived", levels_due.size()));
				end
			end
			words_in_flight <= levels_due.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
module tb_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = '0;
	logic [3:0]  pattern_number = '0;
	logic [1:0]  voice = '0;
	logic [5:0]  slot = '0;
	logic [15:0] value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        buzzer;
	logic        led;
	logic        mixed_high;
	logic [5:0]  order_position;
	logic [5:0]  step_position;
	logic        end_check = 1'b0;
	int unsigned mismatch_count;
	int unsigned words_in_flight;

	bit in_gaps = 1'b1;
	bit out_gaps = 1'b1;
	bit hold_out = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	three_voice_tracker_tone_generator_core u_top (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .mode, .pattern_number, .voice, .slot, .value,
		.out_valid, .out_stall, .buzzer, .led, .mixed_high, .order_position, .step_position
	);

	tvt_scoreboard u_check (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.in_valid, .in_stall, .mode, .pattern_number, .voice, .slot, .value,
		.out_valid, .out_stall, .buzzer, .led, .mixed_high, .order_position, .step_position,
		.end_check, .fail_count(mismatch_count), .words_in_flight
	);

	function automatic int gap_len(input bit enabled);
		int r;
		if (!enabled) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [5:0] pick_note();
		if ($urandom_range(0, 3) == 0) return 6'd0;
		return 6'($urandom_range(1, 63));
	endfunction

	task automatic send_word(input tvt_pkg::mode_t m, input logic [3:0] pn,
			input logic [1:0] vc, input logic [5:0] sl, input logic [15:0] val);
		int g;
		in_valid <= 1'b1;
		mode <= m;
		pattern_number <= pn;
		voice <= vc;
		slot <= sl;
		value <= val;
		do @(posedge clk); while (in_stall);
		g = gap_len(in_gaps);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain_words();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input tvt_pkg::reg_idx_t r, input logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_song(input int nl, input int dt, input int sl, input int lp);
		drain_words();
		cfg_write(tvt_pkg::REG_STEP_TICKS, 32'(nl));
		cfg_write(tvt_pkg::REG_DUTY, 32'(dt));
		cfg_write(tvt_pkg::REG_SONG_LENGTH, 32'(sl));
		cfg_write(tvt_pkg::REG_LOOP_START, 32'(lp));
	endtask

	task automatic random_word();
		int          r;
		logic [15:0] val;
		r = $urandom_range(0, 99);
		val = 16'($urandom);
		if (r < 78) begin
			send_word(tvt_pkg::MODE_TICK, 4'($urandom), 2'($urandom), 6'($urandom), val);
		end else begin
			if ($urandom_range(0, 3) == 0) val[5:0] = '0;
			send_word(tvt_pkg::mode_t'($urandom_range(1, 3)), 4'($urandom),
				2'($urandom_range(0, 3)), 6'($urandom), val);
		end
	endtask

	// receiver side: random stalls, mostly short, plus one long hold on request
	initial begin
		int k;
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_out = 1'b0;
				out_stall <= 1'b0;
			end else if (out_gaps && $urandom_range(0, 99) < 25) begin
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int nl;
		int dt;
		int sl;
		int lp;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cells outside the pattern store are dropped
		send_word(tvt_pkg::MODE_PAT, 4'd15, 2'd3, 6'd0, 16'hffff);
		send_word(tvt_pkg::MODE_PAT, 4'd0, 2'd0, 6'd63, 16'h0001);
		send_word(tvt_pkg::MODE_PAT, 4'd7, 2'd2, 6'd48, 16'h002a);

		// every table entry is written before the first tick can read it
		for (int n = 0; n < tvt_pkg::NOTES_DEF; n++) begin
			send_word(tvt_pkg::MODE_FREQ, 4'($urandom), 2'($urandom), 6'(n),
				(n == 0) ? 16'hffff : (n == 1) ? 16'h0000 : 16'($urandom));
		end
		for (int o = 0; o < tvt_pkg::ORDER_DEPTH_DEF; o++) begin
			send_word(tvt_pkg::MODE_ORD, 4'($urandom), 2'($urandom), 6'(o), 16'($urandom));
		end
		for (int p = 0; p < tvt_pkg::PATTERNS_DEF; p++) begin
			for (int v = 0; v < tvt_pkg::VOICES; v++) begin
				for (int s = 0; s < tvt_pkg::STEPS_DEF; s++) begin
					send_word(tvt_pkg::MODE_PAT, 4'(p), 2'(v), 6'(s),
						{10'($urandom), pick_note()});
				end
			end
		end

		// ticks under the power-up settings
		send_word(tvt_pkg::MODE_TICK, 4'h0, 2'd0, 6'h00, 16'h0000);
		send_word(tvt_pkg::MODE_TICK, 4'hf, 2'd3, 6'h3f, 16'hffff);
		send_word(tvt_pkg::MODE_TICK, 4'h5, 2'd1, 6'h2a, 16'h5555);

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					// zero length: every tick is a step, empty song jumps to the loop point
					nl = 0; dt = 0; sl = 0; lp = 63;
				end
				1: begin
					// long song runs off the end of the order list
					nl = 1; dt = $urandom_range(0, 65535); sl = 127; lp = 62;
				end
				2: begin
					nl = 65535; dt = 65535; sl = 64; lp = 0;
				end
				default: begin
					nl = $urandom_range(0, 3);
					dt = $urandom_range(0, 65535);
					sl = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(0, 127);
					lp = $urandom_range(0, 63);
				end
			endcase
			set_song(nl, dt, sl, lp);
			in_gaps = ($urandom_range(0, 3) != 0);
			out_gaps = ($urandom_range(0, 3) != 0);
			if (p == 4) begin
				// back up the whole pipe while the sender keeps pushing
				in_gaps = 1'b0;
				hold_out = 1'b1;
			end
			for (int i = 0; i < 80; i++) begin
				if (p == 4 && i == 30) in_gaps = 1'b1;
				if (p == 5 && i == 40) drain_words();
				random_word();
			end
		end

		drain_words();
		repeat (8) @(posedge clk);
		end_check <= 1'b1;
		repeat (2) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
